### rtl/core/assert_macros.svh
// Assertion macros shared by the point to segment distance RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PSD_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("point_segment_distance check failed");

// next-cycle implication, checked during reset too
`define PSD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error("point_segment_distance check failed");

`endif

### rtl/core/psd_pkg.sv
// Package with constants of the point to segment distance block
`timescale 1ns / 1ps
`default_nettype none
package psd_pkg;
    localparam int OUT_BITS    = 34;
    localparam int THR_BITS    = 63;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 64;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_AW-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_AW-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_AW-1:0] REG_END_X   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_END_Y   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_THR_SQ  = 3'd4;

    localparam logic [THR_BITS-1:0] THR_RESET = 63'd1;
endpackage
`default_nettype wire

### rtl/core/point_segment_distance.sv
// Top level: point to segment distance with config registers and output skid
//
//  channel  | dir | handshake          | payload
//  s_       | in  | s_tvalid/s_tready  | s_tdata: point_x, point_y
//  m_       | out | m_tvalid/m_tready  | m_tdata: distance, on_segment
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_addr index, cfg_data value
//
//  One item per cycle sustained while the skid is empty; each item passes the front pipeline,
//  one divider cell per quotient bit, one root cell per root bit and the output register.
//  Reset clears all valid bits and loads the register defaults; no clearing pass.
//  A stalled result moves into a one-item skid; the pipeline holds only while the skid is full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module point_segment_distance #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // point_x, point_y, zero fill
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // distance, on_segment, zero fill
    output logic [psd_pkg::OUT_TDATA_W-1:0]          m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [psd_pkg::CFG_AW-1:0]          cfg_addr,
    input  wire logic [psd_pkg::CFG_DW-1:0]          cfg_data
);
    localparam int C   = COORD_BITS;
    localparam int SW  = 2 * C + 3;
    localparam int NW  = 2 * SW;
    localparam int QW  = 2 * C + 2;
    localparam int RW  = C + 1;
    localparam int OB  = psd_pkg::OUT_BITS;
    localparam int TB  = psd_pkg::THR_BITS;
    localparam int XW  = (RW > OB) ? RW : OB;
    localparam int XQ  = (QW > TB) ? QW : TB;
    localparam int PAD = psd_pkg::OUT_TDATA_W - OB - 1;

    logic signed [C-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [TB-1:0]       thr_reg;

    logic en;

    logic          f_v;
    logic [NW-1:0] f_nn;
    logic [SW-1:0] f_mm;

    logic          div_v   [QW+1];
    logic [NW-1:0] div_rem [QW+1];
    logic [SW-1:0] div_mm  [QW+1];
    logic [QW-1:0] div_q   [QW+1];

    logic          sq_v    [RW+1];
    logic [QW-1:0] sq_rem  [RW+1];
    logic [RW-1:0] sq_root [RW+1];
    logic          sq_on   [RW+1];

    logic          pv;
    logic [XW-1:0] root_x;
    logic [OB-1:0] dist_sat;

    logic          out_valid_reg, skid_valid_reg;
    logic [OB-1:0] out_dist_reg, skid_dist_reg;
    logic          out_on_reg, skid_on_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            ex_reg  <= '0;
            ey_reg  <= '0;
            thr_reg <= psd_pkg::THR_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                psd_pkg::REG_START_X: sx_reg  <= cfg_data[C-1:0];
                psd_pkg::REG_START_Y: sy_reg  <= cfg_data[C-1:0];
                psd_pkg::REG_END_X:   ex_reg  <= cfg_data[C-1:0];
                psd_pkg::REG_END_Y:   ey_reg  <= cfg_data[C-1:0];
                psd_pkg::REG_THR_SQ:  thr_reg <= cfg_data[TB-1:0];
                default: ;
            endcase
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    psd_front #(.C(C)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_v    (s_tvalid),
        .point_x ($signed(s_tdata[C-1:0])),
        .point_y ($signed(s_tdata[2*C-1:C])),
        .start_x (sx_reg),
        .start_y (sy_reg),
        .end_x   (ex_reg),
        .end_y   (ey_reg),
        .out_v   (f_v),
        .out_nn  (f_nn),
        .out_mm  (f_mm)
    );

    assign div_v[0]   = f_v;
    assign div_rem[0] = f_nn;
    assign div_mm[0]  = f_mm;
    assign div_q[0]   = '0;

    for (genvar i = 0; i < QW; i++) begin : g_div
        psd_div_cell #(.NW(NW), .MW(SW), .QW(QW), .B(QW - 1 - i)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_v    (div_v[i]),
            .in_rem  (div_rem[i]),
            .in_mm   (div_mm[i]),
            .in_q    (div_q[i]),
            .out_v   (div_v[i+1]),
            .out_rem (div_rem[i+1]),
            .out_mm  (div_mm[i+1]),
            .out_q   (div_q[i+1])
        );
    end

    assign sq_v[0]    = div_v[QW];
    assign sq_rem[0]  = div_q[QW];
    assign sq_root[0] = '0;
    assign sq_on[0]   = XQ'(div_q[QW]) < XQ'(thr_reg);

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        psd_sqrt_cell #(.QW(QW), .RW(RW), .J(RW - 1 - j)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_v     (sq_v[j]),
            .in_rem   (sq_rem[j]),
            .in_root  (sq_root[j]),
            .in_on    (sq_on[j]),
            .out_v    (sq_v[j+1]),
            .out_rem  (sq_rem[j+1]),
            .out_root (sq_root[j+1]),
            .out_on   (sq_on[j+1])
        );
    end

    assign pv       = sq_v[RW];
    assign root_x   = XW'(sq_root[RW]);
    assign dist_sat = (root_x > XW'({OB{1'b1}})) ? {OB{1'b1}} : root_x[OB-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_tready) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (pv) begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_dist_reg <= skid_dist_reg;
                out_on_reg   <= skid_on_reg;
            end
        end else if (pv) begin
            if (!out_valid_reg || m_tready) begin
                out_dist_reg <= dist_sat;
                out_on_reg   <= sq_on[RW];
            end else begin
                skid_dist_reg <= dist_sat;
                skid_on_reg   <= sq_on[RW];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD{1'b0}}, out_on_reg, out_dist_reg};

    `PSD_ASSERT_IMP(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `PSD_ASSERT_IMP(a_skid_fill_on_stall, $rose(skid_valid_reg),
        $past(out_valid_reg) && !$past(m_tready))
    `PSD_ASSERT_IMP(a_zero_thr_never_on, out_valid_reg && thr_reg == '0, !out_on_reg)
    `PSD_ASSERT_NEXT(a_reset_clears_out, !aresetn, !out_valid_reg && !skid_valid_reg)
endmodule
`default_nettype wire

### rtl/core/psd_front.sv
// Front pipeline: differences, products, case select and squared numerator
`timescale 1ns / 1ps
`default_nettype none
module psd_front #(
    parameter int C = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_v,
    input  wire logic signed [C-1:0]   point_x,
    input  wire logic signed [C-1:0]   point_y,
    input  wire logic signed [C-1:0]   start_x,
    input  wire logic signed [C-1:0]   start_y,
    input  wire logic signed [C-1:0]   end_x,
    input  wire logic signed [C-1:0]   end_y,
    output logic                       out_v,
    output logic [2*(2*C+3)-1:0]       out_nn,
    output logic [2*C+2:0]             out_mm
);
    localparam int DW = C + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int NW = 2 * SW;
    localparam int LO = SW / 2;
    localparam int HI = SW - LO;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    logic signed [DW-1:0] px_reg, py_reg, ex_reg, ey_reg;
    logic signed [DW-1:0] dx, dy;

    logic signed [PW-1:0] pxdx_reg, pydy_reg, pxdy_reg, pydx_reg;
    logic signed [PW-1:0] sqpx_reg, sqpy_reg, sqex_reg, sqey_reg, sqdx_reg, sqdy_reg;

    logic signed [SW-1:0] num_reg, crs_reg;
    logic [SW-1:0]        den_reg, sa_reg, sb_reg;

    logic                 crs4_reg;
    logic [SW-1:0]        mag4_reg, mm4_reg;
    logic                 crs4_next;
    logic [SW-1:0]        mag4_next, mm4_next;
    logic [SW-1:0]        crs_abs;

    logic                 crs5_reg;
    logic [2*HI-1:0]      hh_reg;
    logic [HI+LO-1:0]     hl_reg;
    logic [2*LO-1:0]      ll_reg;
    logic [SW-1:0]        mag5_reg, mm5_reg;
    logic [HI-1:0]        hi_part;
    logic [LO-1:0]        lo_part;

    logic [NW-1:0]        nn_reg, nn_next;
    logic [SW-1:0]        mm6_reg;

    assign dx = DW'(end_x) - DW'(start_x);
    assign dy = DW'(end_y) - DW'(start_y);

    assign crs_abs = crs_reg[SW-1] ? $unsigned(-crs_reg) : $unsigned(crs_reg);
    assign hi_part = mag4_reg[SW-1:LO];
    assign lo_part = mag4_reg[LO-1:0];

    always_comb begin
        crs4_next = 1'b0;
        mag4_next = sa_reg;
        mm4_next  = SW'(1);
        if (den_reg == '0 || num_reg[SW-1] || num_reg == '0) begin
            mag4_next = sa_reg;
        end else if ($unsigned(num_reg) >= den_reg) begin
            mag4_next = sb_reg;
        end else begin
            crs4_next = 1'b1;
            mag4_next = crs_abs;
            mm4_next  = den_reg;
        end
    end

    always_comb begin
        if (crs5_reg) begin
            nn_next = (NW'(hh_reg) << (2 * LO)) + (NW'(hl_reg) << (LO + 1)) + NW'(ll_reg);
        end else begin
            nn_next = NW'(mag5_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= DW'(point_x) - DW'(start_x);
            py_reg   <= DW'(point_y) - DW'(start_y);
            ex_reg   <= DW'(point_x) - DW'(end_x);
            ey_reg   <= DW'(point_y) - DW'(end_y);

            pxdx_reg <= px_reg * dx;
            pydy_reg <= py_reg * dy;
            pxdy_reg <= px_reg * dy;
            pydx_reg <= py_reg * dx;
            sqpx_reg <= px_reg * px_reg;
            sqpy_reg <= py_reg * py_reg;
            sqex_reg <= ex_reg * ex_reg;
            sqey_reg <= ey_reg * ey_reg;
            sqdx_reg <= dx * dx;
            sqdy_reg <= dy * dy;

            num_reg  <= SW'(pxdx_reg) + SW'(pydy_reg);
            crs_reg  <= SW'(pxdy_reg) - SW'(pydx_reg);
            den_reg  <= $unsigned(SW'(sqdx_reg) + SW'(sqdy_reg));
            sa_reg   <= $unsigned(SW'(sqpx_reg) + SW'(sqpy_reg));
            sb_reg   <= $unsigned(SW'(sqex_reg) + SW'(sqey_reg));

            crs4_reg <= crs4_next;
            mag4_reg <= mag4_next;
            mm4_reg  <= mm4_next;

            crs5_reg <= crs4_reg;
            hh_reg   <= hi_part * hi_part;
            hl_reg   <= hi_part * lo_part;
            ll_reg   <= lo_part * lo_part;
            mag5_reg <= mag4_reg;
            mm5_reg  <= mm4_reg;

            nn_reg   <= nn_next;
            mm6_reg  <= mm5_reg;
        end
    end

    assign out_v  = v6_reg;
    assign out_nn = nn_reg;
    assign out_mm = mm6_reg;
endmodule
`default_nettype wire

### rtl/core/psd_div_cell.sv
// Divider cell: one restoring quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module psd_div_cell #(
    parameter int NW = 134,
    parameter int MW = 67,
    parameter int QW = 66,
    parameter int B  = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_v,
    input  wire logic [NW-1:0] in_rem,
    input  wire logic [MW-1:0] in_mm,
    input  wire logic [QW-1:0] in_q,
    output logic               out_v,
    output logic [NW-1:0]      out_rem,
    output logic [MW-1:0]      out_mm,
    output logic [QW-1:0]      out_q
);
    logic          v_reg;
    logic [NW-1:0] rem_reg, rem_next, mm_ext;
    logic [MW-1:0] mm_reg;
    logic [QW-1:0] q_reg, q_next;
    logic          take;

    always_comb begin
        mm_ext   = NW'(in_mm);
        take     = (in_rem >> B) >= mm_ext;
        rem_next = take ? in_rem - (mm_ext << B) : in_rem;
        q_next   = take ? (in_q | (QW'(1) << B)) : in_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            mm_reg  <= in_mm;
            q_reg   <= q_next;
        end
    end

    assign out_v   = v_reg;
    assign out_rem = rem_reg;
    assign out_mm  = mm_reg;
    assign out_q   = q_reg;
endmodule
`default_nettype wire

### rtl/core/psd_sqrt_cell.sv
// Square root cell: one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module psd_sqrt_cell #(
    parameter int QW = 66,
    parameter int RW = 33,
    parameter int J  = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_v,
    input  wire logic [QW-1:0] in_rem,
    input  wire logic [RW-1:0] in_root,
    input  wire logic          in_on,
    output logic               out_v,
    output logic [QW-1:0]      out_rem,
    output logic [RW-1:0]      out_root,
    output logic               out_on
);
    logic          v_reg, on_reg;
    logic [QW-1:0] rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [QW:0]   trial;
    logic          take;

    always_comb begin
        trial     = ((QW + 1)'(in_root) << (J + 1)) | ((QW + 1)'(1) << (2 * J));
        take      = {1'b0, in_rem} >= trial;
        rem_next  = take ? QW'({1'b0, in_rem} - trial) : in_rem;
        root_next = take ? (in_root | (RW'(1) << J)) : in_root;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            on_reg   <= in_on;
        end
    end

    assign out_v    = v_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;
    assign out_on   = on_reg;
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for point_segment_distance with an exact distance predictor
`timescale 1ns / 1ps
class dist_board;
    typedef struct {
        logic [psd_pkg::OUT_BITS-1:0] distance;
        logic                         on_segment;
    } dist_result_t;

    dist_result_t expected_q[$];
    longint seg_sx, seg_sy, seg_ex, seg_ey;
    logic [psd_pkg::THR_BITS-1:0] thr_sq;
    int errs;

    function new();
        seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0;
        thr_sq = psd_pkg::THR_RESET;
        errs = 0;
    endfunction

    function void set_reg(logic [psd_pkg::CFG_AW-1:0] idx, logic [63:0] val);
        logic signed [31:0] c;
        c = val[31:0];
        case (idx)
            psd_pkg::REG_START_X: seg_sx = c;
            psd_pkg::REG_START_Y: seg_sy = c;
            psd_pkg::REG_END_X:   seg_ex = c;
            psd_pkg::REG_END_Y:   seg_ey = c;
            psd_pkg::REG_THR_SQ:  thr_sq = val[62:0];
            default: ;
        endcase
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y);
        logic signed [255:0] px, py, dx, dy, qx, qy, num, den, nn, mm, cr, lim, q, c;
        dist_result_t r;
        px = longint'(x) - seg_sx;
        py = longint'(y) - seg_sy;
        dx = seg_ex - seg_sx;
        dy = seg_ey - seg_sy;
        qx = longint'(x) - seg_ex;
        qy = longint'(y) - seg_ey;
        num = px * dx + py * dy;
        den = dx * dx + dy * dy;
        if (den == 0 || num <= 0) begin
            nn = px * px + py * py;
            mm = 1;
        end else if (num >= den) begin
            nn = qx * qx + qy * qy;
            mm = 1;
        end else begin
            cr = px * dy - py * dx;
            nn = cr * cr;
            mm = den;
        end
        lim = {192'd0, 1'b0, thr_sq};
        r.on_segment = nn < lim * mm;
        lim = mm << (2 * psd_pkg::OUT_BITS);
        r.distance = '0;
        if (nn >= lim) begin
            r.distance = '1;
        end else begin
            q = nn / mm;
            for (int b = psd_pkg::OUT_BITS - 1; b >= 0; b--) begin
                c = r.distance | (256'd1 << b);
                if (c * c <= q) r.distance = c[psd_pkg::OUT_BITS-1:0];
            end
        end
        expected_q.push_back(r);
    endfunction

    function void check_result(logic [psd_pkg::OUT_TDATA_W-1:0] tdata);
        dist_result_t e;
        if (expected_q.size() == 0) begin
            $error("unexpected item: tdata %h", tdata);
            errs++;
            return;
        end
        e = expected_q.pop_front();
        if (tdata[psd_pkg::OUT_BITS-1:0] !== e.distance) begin
            $error("distance: expected %h actual %h", e.distance,
                   tdata[psd_pkg::OUT_BITS-1:0]);
            errs++;
        end
        if (tdata[psd_pkg::OUT_BITS] !== e.on_segment) begin
            $error("on_segment: expected %b actual %b", e.on_segment,
                   tdata[psd_pkg::OUT_BITS]);
            errs++;
        end
    endfunction
endclass

module tb_top;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [psd_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [psd_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [psd_pkg::CFG_DW-1:0] cfg_data = '0;

    dist_board board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_req = 1'b0;
    int hold_left = 0;
    int cycles = 0;

    point_segment_distance dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 300000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);

    task automatic cfg_write(logic [psd_pkg::CFG_AW-1:0] idx, logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_segment(longint sx, longint sy, longint ex, longint ey,
                               logic [63:0] thr);
        cfg_write(psd_pkg::REG_START_X, sx);
        cfg_write(psd_pkg::REG_START_Y, sy);
        cfg_write(psd_pkg::REG_END_X, ex);
        cfg_write(psd_pkg::REG_END_Y, ey);
        cfg_write(psd_pkg::REG_THR_SQ, thr);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_point(x, y);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
        endcase
    endfunction

    task automatic random_points(int count);
        longint x, y;
        int k;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 60) begin
                k = $urandom_range(20) - 2;
                x = board.seg_sx + (board.seg_ex - board.seg_sx) * k / 16
                    + $signed($urandom_range(2000)) - 1000;
                y = board.seg_sy + (board.seg_ey - board.seg_sy) * k / 16
                    + $signed($urandom_range(2000)) - 1000;
                send_point(x[31:0], y[31:0]);
            end else begin
                send_point(pick_coord(), pick_coord());
            end
        end
    endtask

    function automatic logic [63:0] pick_thr();
        case ($urandom_range(3))
            0: return 64'd0;
            1: return {$urandom(), $urandom()};
            default: return 64'($urandom_range(1 << 20)) << $urandom_range(30);
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: zero-length segment at the origin, threshold one
        send_point(32'd0, 32'd0);
        send_point(32'd1, 32'd0);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000);
        drain();

        set_segment(0, 0, 10 << 16, 0, 64'h1_0000_0000);
        send_point(-(5 << 16), 3 << 16);
        send_point(15 << 16, -(4 << 16));
        send_point(4 << 16, 2 << 16);
        send_point(7 << 16, 0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h7fff_ffff);
        send_point(0, 0);
        send_point(10 << 16, 0);
        drain();

        set_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                    64'hffff_ffff_ffff_ffff);
        send_point(32'h8000_0000, 32'h7fff_ffff);
        send_point(32'h7fff_ffff, 32'h8000_0000);
        send_point(0, 0);
        send_point(32'hffff_ffff, 32'h0000_0001);
        send_point(32'h8000_0000, 32'h8000_0000);
        drain();

        cfg_write(3'd5, 64'hdead_beef);
        cfg_write(3'd7, 64'h1234);
        set_segment(64'hffff_ffff_0001_0000, 64'h5555_0002_0000, 5 << 16, 5 << 16, 0);
        send_point(1 << 16, 2 << 16);
        send_point(3 << 16, 3 << 16);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 50 : 0;
            recv_idle_pct = (mode == 0) ? 50 : (mode == 1) ? 9 : 0;
            for (int sub = 0; sub < 3; sub++) begin
                case (sub)
                    0: set_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                                   pick_thr());
                    1: begin
                        longint p;
                        p = $signed(pick_coord());
                        set_segment(p, p + 7, p, p + 7, pick_thr());
                    end
                    default: set_segment($signed($urandom_range(1 << 22)),
                                         -$signed($urandom_range(1 << 22)),
                                         $signed($urandom_range(1 << 23)),
                                         $signed($urandom_range(1 << 21)), pick_thr());
                endcase
                if (mode == 2 && sub == 0) hold_req = 1'b1;
                random_points(160);
                drain();
            end
        end

        if (board.errs == 0 && board.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
